>>> hw/rtl/ssg_pkg.sv
// Shared types, register codes and step tables for the stepper step gate.
`default_nettype none

package ssg_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_STEP_INTERVAL = 3'd0,
        CFG_MIN_REAL      = 3'd1,
        CFG_LOWER_LIMIT   = 3'd2,
        CFG_UPPER_LIMIT   = 3'd3,
        CFG_RANGE_ON      = 3'd4,
        CFG_MODE          = 3'd5,
        CFG_DRIVER        = 3'd6,
        CFG_COMP_ON       = 3'd7
    } t_cfg_idx;

    // Input command codes.
    localparam logic CMD_ROLL = 1'b0;
    localparam logic CMD_STOP = 1'b1;

    // Microstep modes.
    localparam logic [2:0] MODE_FULL    = 3'd0;
    localparam logic [2:0] MODE_HALF    = 3'd1;
    localparam logic [2:0] MODE_QUARTER = 3'd2;
    localparam logic [2:0] MODE_EIGHTH  = 3'd3;
    localparam logic [2:0] MODE_16TH    = 3'd4;
    localparam logic [2:0] MODE_32ND    = 3'd5;

    // Driver kinds.
    localparam logic DRV_TABLE32 = 1'b0;
    localparam logic DRV_TABLE16 = 1'b1;

    localparam int CFG_DATA_W = 32;
    localparam int INC_W      = 6;
    localparam int MOVED_W    = 7;

    typedef struct packed {
        logic [31:0] step_interval;
        logic [31:0] min_real_interval;
        logic [31:0] lower_limit;
        logic [31:0] upper_limit;
        logic        range_check_on;
        logic [2:0]  microstep_mode;
        logic        driver_kind;
        logic        compensation_on;
    } t_cfg;

    // Position increment for a microstep mode and driver kind.
    function automatic logic [INC_W-1:0] step_inc(input logic drv, input logic [2:0] mode);
        logic [INC_W-1:0] v;
        v = 6'd1;
        unique case (mode)
            MODE_FULL:    v = (drv == DRV_TABLE32) ? 6'd32 : 6'd16;
            MODE_HALF:    v = (drv == DRV_TABLE32) ? 6'd16 : 6'd8;
            MODE_QUARTER: v = (drv == DRV_TABLE32) ? 6'd8  : 6'd4;
            MODE_EIGHTH:  v = (drv == DRV_TABLE32) ? 6'd4  : 6'd2;
            MODE_16TH:    v = (drv == DRV_TABLE32) ? 6'd2  : 6'd1;
            MODE_32ND:    v = 6'd1;
            default:      v = 6'd1;
        endcase
        return v;
    endfunction

    // Microstep select pins (MS1 in bit 0) for a mode and driver kind.
    function automatic logic [2:0] step_pins(input logic drv, input logic [2:0] mode);
        logic [2:0] v;
        v = 3'b111;
        unique case (mode)
            MODE_FULL:    v = 3'b000;
            MODE_HALF:    v = 3'b001;
            MODE_QUARTER: v = 3'b010;
            MODE_EIGHTH:  v = 3'b011;
            MODE_16TH:    v = (drv == DRV_TABLE32) ? 3'b100 : 3'b111;
            MODE_32ND:    v = 3'b111;
            default:      v = 3'b111;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ssg_cfg.sv
// Configuration register file of the stepper step gate.
`default_nettype none

module ssg_cfg (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [2:0]                   i_cfg_index,
    input  wire logic [ssg_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output ssg_pkg::t_cfg                     o_cfg,
    output logic                              o_sched_clr
);
    import ssg_pkg::*;

    t_cfg r_cfg;
    t_cfg_idx w_idx;

    assign w_idx = t_cfg_idx'(i_cfg_index);
    assign o_cfg = r_cfg;
    // Any write to the compensation register also forgets the schedule.
    assign o_sched_clr = i_cfg_we && (w_idx == CFG_COMP_ON);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (w_idx)
                CFG_STEP_INTERVAL: r_cfg.step_interval     <= i_cfg_wdata;
                CFG_MIN_REAL:      r_cfg.min_real_interval <= i_cfg_wdata;
                CFG_LOWER_LIMIT:   r_cfg.lower_limit       <= i_cfg_wdata;
                CFG_UPPER_LIMIT:   r_cfg.upper_limit       <= i_cfg_wdata;
                CFG_RANGE_ON:      r_cfg.range_check_on    <= i_cfg_wdata[0];
                CFG_MODE: begin
                    // Codes above thirty-second step are dropped.
                    if (i_cfg_wdata[2:0] <= MODE_32ND) begin
                        r_cfg.microstep_mode <= i_cfg_wdata[2:0];
                    end
                end
                CFG_DRIVER:        r_cfg.driver_kind       <= i_cfg_wdata[0];
                CFG_COMP_ON:       r_cfg.compensation_on   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/stepper_step_gate.sv
// Top level of the stepper step gate: handshakes, step decision and motor state.
`default_nettype none

// Stepper step gate. Each input item is a roll request (one step in the given
// direction at time now_us) or a stop, which forgets both step timestamps. A
// roll steps only when at least step_interval microseconds have passed since
// the scheduled last step, at least min_real_interval since the last actual
// step, and, with range checking on, the new position stays inside the
// window [lower_limit, upper_limit]. A timestamp of zero means "no step yet".
// Every item produces exactly one result item. An accepted item sits in an
// input register; when the result register is free or being read, decision
// and state update go in one pass into the result register, so the block
// takes one item per clock while m_axis_tready is high. The input register also
// acts as a skid stage: while a result waits on m_axis_tready, one more item is
// taken. Configuration writes are meant only while no item is in flight.
module stepper_step_gate #(
    parameter int TIME_BITS = 32,
    parameter int POS_BITS  = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port.
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [ssg_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // Request stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // [0] direction, [32:1] now_us, rest zero
    input  wire logic        s_axis_tuser,  // [0] command
    // Result stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [79:0]      m_axis_tdata   // [0] stepped, [1] dir_level, [8:2] moved,
                                            // [40:9] position_now, [72:41] real_interval,
                                            // [73] power_enabled, [76:74] mode_pins,
                                            // rest zero
);
    import ssg_pkg::*;

    // Width of the full-precision range compare.
    localparam int CW = ((POS_BITS > 33) ? POS_BITS : 33) + 1;

    t_cfg w_cfg;
    logic w_sched_clr;

    ssg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg),
        .o_sched_clr (w_sched_clr)
    );

    // Input register.
    logic        r_in_valid;
    logic        r_cmd;
    logic        r_back;
    logic [31:0] r_now;

    // Motor state.
    logic [POS_BITS-1:0]  r_position;
    logic [TIME_BITS-1:0] r_sched;
    logic [TIME_BITS-1:0] r_actual;
    logic [TIME_BITS-1:0] r_real_int;
    logic                 r_power;
    logic                 r_dir;

    // Result register.
    logic               r_out_valid;
    logic               r_o_stepped;
    logic               r_o_dir;
    logic [MOVED_W-1:0] r_o_moved;
    logic [31:0]        r_o_pos;
    logic [31:0]        r_o_real;
    logic               r_o_power;
    logic [2:0]         r_o_pins;

    logic w_advance;
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    // Times taken to the working width.
    logic [63:0]          w_now64, w_si64, w_mi64;
    logic [TIME_BITS-1:0] w_now, w_si, w_mi, w_el_sched, w_el_actual;
    assign w_now64     = {32'd0, r_now};
    assign w_si64      = {32'd0, w_cfg.step_interval};
    assign w_mi64      = {32'd0, w_cfg.min_real_interval};
    assign w_now       = w_now64[TIME_BITS-1:0];
    assign w_si        = w_si64[TIME_BITS-1:0];
    assign w_mi        = w_mi64[TIME_BITS-1:0];
    assign w_el_sched  = w_now - r_sched;
    assign w_el_actual = w_now - r_actual;

    logic [INC_W-1:0] w_inc;
    assign w_inc = step_inc(w_cfg.driver_kind, w_cfg.microstep_mode);

    // Range test without wrap: the window bounds are widened before the
    // increment is applied.
    logic signed [CW-1:0] w_pos_x, w_lo_plus, w_up_minus;
    logic [CW-1:0]        w_inc_x;
    assign w_pos_x    = $signed({{(CW-POS_BITS){r_position[POS_BITS-1]}}, r_position});
    assign w_inc_x    = {{(CW-INC_W){1'b0}}, w_inc};
    assign w_lo_plus  = $signed({{(CW-32){w_cfg.lower_limit[31]}}, w_cfg.lower_limit})
                        + $signed(w_inc_x);
    assign w_up_minus = $signed({{(CW-32){w_cfg.upper_limit[31]}}, w_cfg.upper_limit})
                        - $signed(w_inc_x);

    logic w_time_ok, w_range_bad, w_go;
    assign w_time_ok   = !(w_el_sched < w_si) && !(w_el_actual < w_mi);
    assign w_range_bad = w_cfg.range_check_on &&
                         ((r_back && (w_pos_x < w_lo_plus)) ||
                          (!r_back && (w_pos_x > w_up_minus)));
    assign w_go        = (r_cmd == CMD_ROLL) && w_time_ok && !w_range_bad;

    logic [MOVED_W-1:0] w_step_delta, w_moved;
    assign w_step_delta = r_back ? (MOVED_W'(0) - {1'b0, w_inc}) : {1'b0, w_inc};
    assign w_moved      = w_go ? w_step_delta : '0;

    // Next state.
    logic [POS_BITS-1:0]  n_position;
    logic [TIME_BITS-1:0] n_sched, n_actual, n_real_int;
    logic                 n_power, n_dir;

    always_comb begin
        n_position = r_position;
        n_sched    = r_sched;
        n_actual   = r_actual;
        n_real_int = r_real_int;
        n_power    = r_power;
        n_dir      = r_dir;
        if (r_cmd == CMD_STOP) begin
            n_sched  = '0;
            n_actual = '0;
        end else if (w_go) begin
            n_power    = 1'b1;
            n_dir      = r_back;
            n_real_int = (r_actual == '0) ? w_si : w_el_actual;
            n_actual   = w_now;
            n_position = r_position + {{(POS_BITS-MOVED_W){w_step_delta[MOVED_W-1]}},
                                       w_step_delta};
            // Compensation keeps the schedule on its grid once it has a start.
            n_sched    = ((r_sched == '0) || !w_cfg.compensation_on) ? w_now
                                                                     : r_sched + w_si;
        end
    end

    logic [63:0] w_pos64, w_real64;
    assign w_pos64  = 64'(n_position);
    assign w_real64 = 64'(n_real_int);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_position  <= '0;
            r_sched     <= '0;
            r_actual    <= '0;
            r_real_int  <= '0;
            r_power     <= 1'b0;
            r_dir       <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_advance) begin
                r_position <= n_position;
                r_sched    <= n_sched;
                r_actual   <= n_actual;
                r_real_int <= n_real_int;
                r_power    <= n_power;
                r_dir      <= n_dir;
            end else if (w_sched_clr) begin
                r_sched <= '0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd  <= s_axis_tuser;
            r_back <= s_axis_tdata[0];
            r_now  <= s_axis_tdata[32:1];
        end
        if (w_advance) begin
            r_o_stepped <= w_go;
            r_o_dir     <= n_dir;
            r_o_moved   <= w_moved;
            r_o_pos     <= w_pos64[31:0];
            r_o_real    <= w_real64[31:0];
            r_o_power   <= n_power;
            r_o_pins    <= step_pins(w_cfg.driver_kind, w_cfg.microstep_mode);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0, r_o_pins, r_o_power, r_o_real, r_o_pos,
                            r_o_moved, r_o_dir, r_o_stepped};

endmodule

`default_nettype wire

>>> tb/tb_stepper_step_gate.sv
// Self-checking testbench for the stepper step gate: stream driver, monitor and step predictor.
module tb_stepper_step_gate;

    timeunit 1ns;
    timeprecision 1ps;

    import ssg_pkg::*;

    // One request item as the sender sees it.
    typedef struct packed {
        logic        command;
        logic [31:0] now_us;
        logic        direction;
    } t_request;

    // One result item, laid out exactly as m_axis_tdata carries it, lowest field last.
    typedef struct packed {
        logic [2:0]  spare;
        logic [2:0]  mode_pins;
        logic        power_enabled;
        logic [31:0] real_interval;
        logic [31:0] position_now;
        logic [6:0]  moved;
        logic        dir_level;
        logic        stepped;
    } t_result;

    // Receiver stall styles.
    typedef enum logic [1:0] {
        RX_OPEN    = 2'd0,
        RX_RANDOM  = 2'd1,
        RX_PATTERN = 2'd2
    } t_rx_style;

    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 150;

    // Clock, reset and every block input start at a known value.
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [2:0]  i_cfg_index   = '0;
    logic [31:0] i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;  // [0] direction, [32:1] now_us, rest zero
    logic        s_axis_tuser  = 1'b0; // [0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [79:0] m_axis_tdata;         // [0] stepped, [1] dir_level, [8:2] moved,
                                       // [40:9] position_now, [72:41] real_interval,
                                       // [73] power_enabled, [76:74] mode_pins

    stepper_step_gate dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Predictor copy of the configuration registers, all zero after reset.
    logic [31:0]        cfg_interval = '0;
    logic [31:0]        cfg_min_real = '0;
    logic signed [31:0] cfg_lower    = '0;
    logic signed [31:0] cfg_upper    = '0;
    logic               cfg_range_on = 1'b0;
    logic [2:0]         cfg_mode     = MODE_FULL;
    logic               cfg_drv      = DRV_TABLE32;
    logic               cfg_comp     = 1'b0;

    // Predictor copy of the motor state. A timestamp of zero stands for no step yet.
    logic signed [31:0] mot_pos   = '0;
    logic [31:0]        sched_t   = '0;
    logic [31:0]        actual_t  = '0;
    logic [31:0]        last_real = '0;
    logic               power_on  = 1'b0;
    logic               dir_pin   = 1'b0;

    // Requests waiting to be sent and results waiting to arrive.
    t_request step_requests[$];
    t_result  step_verdicts[$];
    int       requests_in_flight = 0;
    int       error_count        = 0;

    // Handshake bookkeeping shared between the monitor and the driver.
    logic     req_taken = 1'b0;
    t_request cur_req;
    t_result  got_res;
    t_result  want_res;
    int       burst_left = 0;
    int       gap_left   = 0;

    // Receiver stall pattern state.
    t_rx_style   rx_style = RX_OPEN;
    logic [15:0] rx_pattern = '1;
    int unsigned rx_count = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Position increment for a microstep mode: the 1/16 driver has no 32nd step of its own.
    function automatic logic [5:0] step_size(logic drv, logic [2:0] mode);
        if (drv == DRV_TABLE16)
            return (mode == MODE_32ND) ? 6'd1 : (6'd16 >> mode);
        return 6'd32 >> mode;
    endfunction

    // Microstep select pins: the finest mode of either driver drives all three pins high.
    function automatic logic [2:0] select_pins(logic drv, logic [2:0] mode);
        if (mode == MODE_32ND || (drv == DRV_TABLE16 && mode == MODE_16TH))
            return 3'b111;
        return mode;
    endfunction

    // Mirror of a register write. Microstep modes above the finest one are dropped, and any
    // write of the compensation flag forgets the scheduled step time.
    function automatic void apply_reg(t_cfg_idx idx, logic [31:0] v);
        case (idx)
            CFG_STEP_INTERVAL: cfg_interval = v;
            CFG_MIN_REAL:      cfg_min_real = v;
            CFG_LOWER_LIMIT:   cfg_lower = v;
            CFG_UPPER_LIMIT:   cfg_upper = v;
            CFG_RANGE_ON:      cfg_range_on = v[0];
            CFG_MODE:          if (v[2:0] <= MODE_32ND) cfg_mode = v[2:0];
            CFG_DRIVER:        cfg_drv = v[0];
            CFG_COMP_ON: begin
                cfg_comp = v[0];
                sched_t = '0;
            end
            default: ;
        endcase
    endfunction

    // Decides one request and updates the motor state the way the block must.
    function automatic t_result judge_request(t_request rq);
        t_result     r;
        logic        go;
        logic [5:0]  inc;
        logic [6:0]  mag;
        logic [31:0] since_sched;
        logic [31:0] since_actual;
        longint      pos_w;
        r = '0;
        go = 1'b0;
        inc = step_size(cfg_drv, cfg_mode);
        mag = {1'b0, inc};
        if (rq.command == CMD_STOP) begin
            sched_t = '0;
            actual_t = '0;
        end else begin
            // Elapsed times wrap modulo 2^32 like the microsecond counter.
            since_sched = rq.now_us - sched_t;
            since_actual = rq.now_us - actual_t;
            go = (since_sched >= cfg_interval) && (since_actual >= cfg_min_real);
            // The window test runs in 64 bits so that limits near the extremes never wrap.
            if (go && cfg_range_on) begin
                pos_w = longint'(mot_pos);
                if (rq.direction && pos_w < longint'(cfg_lower) + longint'(inc))
                    go = 1'b0;
                if (!rq.direction && pos_w > longint'(cfg_upper) - longint'(inc))
                    go = 1'b0;
            end
            if (go) begin
                power_on = 1'b1;
                dir_pin = rq.direction;
                last_real = (actual_t == '0) ? cfg_interval : since_actual;
                actual_t = rq.now_us;
                r.moved = rq.direction ? 7'd0 - mag : mag;
                mot_pos = mot_pos + {{25{r.moved[6]}}, r.moved};
                if (sched_t == '0 || !cfg_comp)
                    sched_t = actual_t;
                else
                    sched_t = sched_t + cfg_interval;
            end
        end
        r.stepped = go;
        r.dir_level = dir_pin;
        r.position_now = mot_pos;
        r.real_interval = last_real;
        r.power_enabled = power_on;
        r.mode_pins = select_pins(cfg_drv, cfg_mode);
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Monitor. Results are checked before the request of the same edge is predicted: a
    // result leaving at this edge always belongs to an older request.
    always @(posedge i_clk) begin
        req_taken = s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_res = t_result'(m_axis_tdata);
                if (step_verdicts.size() == 0) begin
                    $display("%0t: result with no request outstanding, expected none, actual %h",
                             $time, m_axis_tdata);
                    error_count++;
                end else begin
                    want_res = step_verdicts.pop_front();
                    check_field("stepped", 32'(want_res.stepped), 32'(got_res.stepped));
                    check_field("dir_level", 32'(want_res.dir_level), 32'(got_res.dir_level));
                    check_field("moved", 32'(want_res.moved), 32'(got_res.moved));
                    check_field("position_now", want_res.position_now, got_res.position_now);
                    check_field("real_interval", want_res.real_interval, got_res.real_interval);
                    check_field("power_enabled", 32'(want_res.power_enabled),
                                32'(got_res.power_enabled));
                    check_field("mode_pins", 32'(want_res.mode_pins), 32'(got_res.mode_pins));
                end
            end
            if (req_taken) begin
                step_verdicts.push_back(judge_request(t_request'({s_axis_tuser,
                                                                  s_axis_tdata[32:1],
                                                                  s_axis_tdata[0]})));
                requests_in_flight--;
            end
        end
    end

    // Driver. It sends in bursts of random length separated by random gaps. A valid item is
    // held until it is taken, and the next one follows at once inside a burst.
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || req_taken)) begin
            if (gap_left != 0 || step_requests.size() == 0) begin
                if (gap_left != 0)
                    gap_left--;
                s_axis_tvalid <= 1'b0;
            end else begin
                cur_req = step_requests.pop_front();
                s_axis_tdata <= {7'd0, cur_req.now_us, cur_req.direction};
                s_axis_tuser <= cur_req.command;
                s_axis_tvalid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    // About one burst in four is a long one, and about one in four is
                    // followed directly by the next burst with no gap.
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(1, 8);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // Receiver. It switches among three styles: always ready, random stalls, or a
    // repeating stall pattern that always holds at least one ready cycle.
    always @(negedge i_clk) begin
        rx_count++;
        if (rx_count % 64 == 0) begin
            rx_style = t_rx_style'($urandom_range(0, 2));
            rx_pattern = 16'($urandom) | 16'h0001;
        end
        case (rx_style)
            RX_OPEN:    m_axis_tready <= 1'b1;
            RX_RANDOM:  m_axis_tready <= ($urandom_range(0, 2) != 0);
            default:    m_axis_tready <= rx_pattern[rx_count[3:0]];
        endcase
    end

    task automatic push_item(logic cmd, logic dir, logic [31:0] now);
        step_requests.push_back(t_request'({cmd, now, dir}));
        requests_in_flight++;
    endtask

    // One register write, committed at the rising edge in the middle of the pulse.
    task automatic write_reg(t_cfg_idx idx, logic [31:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= v;
        apply_reg(idx, v);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Waits until every request has been taken and answered, then lets the two-stage
    // pipeline settle before anything else happens.
    task automatic wait_idle();
        while (requests_in_flight != 0 || step_verdicts.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Stimulus: directed items first, then random phases with their own settings.
    initial begin
        logic [31:0] iv, mr, lo, hi, rng, md, dk, cp;
        logic [31:0] clock_us;
        int unsigned span;
        logic        heading;
        int          pick;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: no spacing at all. Steps at time zero leave no timestamp behind,
        // so the second roll again reports a first step.
        push_item(CMD_ROLL, 1'b0, 32'd0);
        push_item(CMD_ROLL, 1'b1, 32'd0);
        push_item(CMD_ROLL, 1'b0, 32'hFFFF_FFFF);
        push_item(CMD_STOP, 1'b0, 32'd0);
        push_item(CMD_ROLL, 1'b1, 32'd5);
        wait_idle();

        // Spacing with compensation: the schedule advances by the interval while the real
        // interval follows the actual step times; a stop makes the next roll a first step.
        write_reg(CFG_STEP_INTERVAL, 32'd100);
        write_reg(CFG_MIN_REAL, 32'd30);
        write_reg(CFG_MODE, 32'(MODE_HALF));
        write_reg(CFG_COMP_ON, 32'd1);
        push_item(CMD_ROLL, 1'b0, 32'd1000);
        push_item(CMD_ROLL, 1'b0, 32'd1050);
        push_item(CMD_ROLL, 1'b1, 32'd1100);
        push_item(CMD_ROLL, 1'b0, 32'd1350);
        push_item(CMD_ROLL, 1'b0, 32'd1360);
        push_item(CMD_ROLL, 1'b1, 32'd1400);
        push_item(CMD_STOP, 1'b1, 32'd1401);
        push_item(CMD_ROLL, 1'b0, 32'd1405);
        wait_idle();

        // A narrow window around the current position with the coarsest step of the 1/16
        // driver: one step each way fits, the next one is refused.
        write_reg(CFG_STEP_INTERVAL, 32'd0);
        write_reg(CFG_MIN_REAL, 32'd0);
        write_reg(CFG_LOWER_LIMIT, mot_pos - 32'sd20);
        write_reg(CFG_UPPER_LIMIT, mot_pos + 32'sd20);
        write_reg(CFG_RANGE_ON, 32'd1);
        write_reg(CFG_DRIVER, 32'(DRV_TABLE16));
        write_reg(CFG_MODE, 32'(MODE_FULL));
        push_item(CMD_ROLL, 1'b0, 32'd2000);
        push_item(CMD_ROLL, 1'b0, 32'd2001);
        push_item(CMD_ROLL, 1'b1, 32'd2002);
        push_item(CMD_ROLL, 1'b1, 32'd2003);
        push_item(CMD_ROLL, 1'b1, 32'd2004);
        wait_idle();

        // Modes six and seven do not exist, so the mode stays as it was.
        write_reg(CFG_MODE, 32'd6);
        write_reg(CFG_MODE, 32'd7);
        push_item(CMD_ROLL, 1'b0, 32'd2005);
        wait_idle();

        // An inverted window at the extremes: with wrapping arithmetic it would look open,
        // at full precision it refuses every step. Thirty-second step on the 1/16 driver.
        write_reg(CFG_LOWER_LIMIT, 32'h7FFF_FFFF);
        write_reg(CFG_UPPER_LIMIT, 32'h8000_0000);
        write_reg(CFG_MODE, 32'(MODE_32ND));
        push_item(CMD_ROLL, 1'b0, 32'd3000);
        push_item(CMD_ROLL, 1'b1, 32'd3001);
        wait_idle();

        // Largest intervals: only a full wrap of the clock since "no step" gets through.
        write_reg(CFG_LOWER_LIMIT, 32'h8000_0000);
        write_reg(CFG_UPPER_LIMIT, 32'h7FFF_FFFF);
        write_reg(CFG_STEP_INTERVAL, 32'hFFFF_FFFF);
        write_reg(CFG_MIN_REAL, 32'hFFFF_FFFF);
        write_reg(CFG_DRIVER, 32'(DRV_TABLE32));
        write_reg(CFG_RANGE_ON, 32'd0);
        push_item(CMD_STOP, 1'b0, 32'hFFFF_FFFF);
        push_item(CMD_ROLL, 1'b0, 32'd5);
        push_item(CMD_ROLL, 1'b1, 32'hFFFF_FFFF);
        push_item(CMD_ROLL, 1'b0, 32'd0);

        // Random phases. The first two use extreme settings, the rest draw their own.
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    iv = '0;
                    mr = '0;
                    lo = 32'h8000_0000;
                    hi = 32'h7FFF_FFFF;
                    rng = 32'd1;
                    md = 32'(MODE_FULL);
                    dk = 32'(DRV_TABLE32);
                    cp = 32'd1;
                end
                1: begin
                    iv = '1;
                    mr = '1;
                    lo = mot_pos - 32'sd100;
                    hi = mot_pos + 32'sd100;
                    rng = 32'd0;
                    md = 32'(MODE_32ND);
                    dk = 32'(DRV_TABLE16);
                    cp = 32'd0;
                end
                default: begin
                    iv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) * $urandom
                                                     : $urandom_range(0, 60);
                    mr = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 60);
                    if ($urandom_range(0, 7) == 0) begin
                        lo = $urandom;
                        hi = $urandom;
                    end else begin
                        lo = mot_pos - $urandom_range(0, 400);
                        hi = mot_pos + $urandom_range(0, 400);
                    end
                    // Flag and mode registers now and then get junk in their upper bits.
                    rng = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1);
                    md = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 7);
                    dk = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1);
                    cp = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1);
                end
            endcase
            write_reg(CFG_STEP_INTERVAL, iv);
            write_reg(CFG_MIN_REAL, mr);
            write_reg(CFG_LOWER_LIMIT, lo);
            write_reg(CFG_UPPER_LIMIT, hi);
            write_reg(CFG_RANGE_ON, rng);
            write_reg(CFG_MODE, md);
            write_reg(CFG_DRIVER, dk);
            write_reg(CFG_COMP_ON, cp);

            // Time advances by steps around the programmed spacing, so both the accepted
            // and the refused rolls are common; some phases start just before the wrap.
            if (cfg_interval < 200 && cfg_min_real < 200)
                span = 2 * ((cfg_interval > cfg_min_real) ? cfg_interval : cfg_min_real) + 8;
            else
                span = 64;
            clock_us = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 255)
                                                   : $urandom_range(1, 100000);
            heading = 1'($urandom_range(0, 1));
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    push_item(CMD_STOP, 1'($urandom_range(0, 1)), $urandom);
                end else if (pick < 10) begin
                    // Noise: a roll at an arbitrary time, or at time zero.
                    push_item(CMD_ROLL, 1'($urandom_range(0, 1)),
                              (pick < 7) ? $urandom : 32'd0);
                end else begin
                    // Runs in one direction so that the window limits are reached.
                    if ($urandom_range(0, 7) == 0)
                        heading = ~heading;
                    clock_us = clock_us + $urandom_range(0, span);
                    push_item(CMD_ROLL, heading, clock_us);
                end
            end
        end

        wait_idle();
        // Anything that still trickles out now has no request behind it.
        repeat (8) @(negedge i_clk);
        if (error_count == 0 && step_verdicts.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
